[rtl/median_by_rank_count_core_macros.svh]
// ----------------------------------------------------------------------------
// median_by_rank_count_core_macros.svh
// Assertion macros shared by the checker of the rank-count median core.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_BY_RANK_COUNT_CORE_MACROS_SVH
`define MEDIAN_BY_RANK_COUNT_CORE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define MBRC_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mbrc implication check failed");

// A stalled beat keeps valid high and its payload stable.
`define MBRC_ASSERT_HOLD(name, vld, rdy, sig) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
    else $error("mbrc stalled beat changed");

`endif

[rtl/mbrc_pkg.sv]
// ----------------------------------------------------------------------------
// mbrc_pkg
// Shared constants and types of the rank-count median core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbrc_pkg;

  localparam int Capacity    = 64;
  localparam int ValueBits   = 32;
  localparam int SampleBits  = 32;
  localparam int MedianBits  = 32;
  localparam int QueueDepth  = 4;

  localparam int IdxBits      = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CntBits      = $clog2(Capacity + 1);
  localparam int QueuePtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntBits = $clog2(QueueDepth + 1);

  typedef logic signed [ValueBits-1:0]  value_t;
  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic signed [MedianBits-1:0] median_t;
  typedef logic [CntBits-1:0]           cnt_t;
  typedef logic [IdxBits-1:0]           idx_t;

  typedef struct packed {
    value_t sample;
    logic   final_item;
  } item_t;

endpackage

[rtl/mbrc_front.sv]
// ----------------------------------------------------------------------------
// mbrc_front
// Input side: accepts beats, sizes samples to the store width, tags the last
// beat of a set and queues them for the search engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbrc_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  mbrc_pkg::sample_t      sample_i,
  input  logic                   final_item_i,
  output logic                   item_valid_o,
  input  logic                   item_ready_i,
  output mbrc_pkg::item_t        item_o
);

  typedef logic [mbrc_pkg::QueuePtrBits-1:0] ptr_t;
  typedef logic [mbrc_pkg::QueueCntBits-1:0] fill_t;

  mbrc_pkg::item_t queue_q [mbrc_pkg::QueueDepth];
  ptr_t            wr_ptr_q, wr_ptr_d;
  ptr_t            rd_ptr_q, rd_ptr_d;
  fill_t           fill_q, fill_d;
  logic            push, pop;
  mbrc_pkg::item_t push_item;

  assign in_ready_o   = (fill_q != fill_t'(mbrc_pkg::QueueDepth));
  assign item_valid_o = (fill_q != '0);
  assign item_o       = queue_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_comb begin
    push_item.sample     = mbrc_pkg::value_t'(sample_i);
    push_item.final_item = final_item_i;
  end

  function automatic ptr_t ptr_inc(ptr_t p);
    if (p == ptr_t'(mbrc_pkg::QueueDepth - 1)) begin
      return '0;
    end
    return p + ptr_t'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + fill_t'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - fill_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= push_item;
    end
  end

endmodule

[rtl/mbrc_back.sv]
// ----------------------------------------------------------------------------
// mbrc_back
// Search engine: writes samples into the value store and, on the last beat
// of a set, counts ranks with one comparator and registers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbrc_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  output logic                   item_ready_o,
  input  mbrc_pkg::item_t        item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output mbrc_pkg::median_t      median_o,
  output logic                   found_o,
  output logic                   overflowed_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CAND,
    S_LATCH,
    S_SCAN,
    S_DONE
  } state_e;

  mbrc_pkg::value_t  store_q [mbrc_pkg::Capacity];
  mbrc_pkg::value_t  rd_data_q;

  state_e            state_q, state_d;
  mbrc_pkg::cnt_t    count_q, count_d;
  logic              ovf_q, ovf_d;
  mbrc_pkg::cnt_t    size_q, size_d;
  mbrc_pkg::cnt_t    target_q, target_d;
  mbrc_pkg::cnt_t    i_q, i_d;
  mbrc_pkg::cnt_t    j_q, j_d;
  mbrc_pkg::cnt_t    rank_q, rank_d;
  logic              pend_q, pend_d;
  mbrc_pkg::value_t  cand_q, cand_d;
  mbrc_pkg::value_t  res_q, res_d;
  logic              hit_q, hit_d;
  logic              out_valid_q, out_valid_d;
  mbrc_pkg::median_t median_q, median_d;
  logic              found_q, found_d;
  logic              ovfl_q, ovfl_d;

  logic              pop;
  logic              wr_en;
  mbrc_pkg::cnt_t    count_nxt;
  mbrc_pkg::cnt_t    i_nxt;
  mbrc_pkg::idx_t    rd_addr;

  assign item_ready_o = (state_q == S_IDLE);
  assign pop          = item_valid_i && item_ready_o;
  assign wr_en        = pop && (count_q < mbrc_pkg::cnt_t'(mbrc_pkg::Capacity));
  assign count_nxt    = count_q + mbrc_pkg::cnt_t'(wr_en);
  assign i_nxt        = i_q + mbrc_pkg::cnt_t'(1);

  assign out_valid_o  = out_valid_q;
  assign median_o     = median_q;
  assign found_o      = found_q;
  assign overflowed_o = ovfl_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    size_d      = size_q;
    target_d    = target_q;
    i_d         = i_q;
    j_d         = j_q;
    rank_d      = rank_q;
    pend_d      = pend_q;
    cand_d      = cand_q;
    res_d       = res_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    median_d    = median_q;
    found_d     = found_q;
    ovfl_d      = ovfl_q;
    rd_addr     = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (pop) begin
          count_d = count_nxt;
          ovf_d   = ovf_q | ~wr_en;
          if (item_i.final_item) begin
            size_d   = count_nxt;
            target_d = (count_nxt >> 1) + mbrc_pkg::cnt_t'(1);
            i_d      = '0;
            state_d  = S_CAND;
          end
        end
      end
      S_CAND: begin
        rd_addr = i_q[mbrc_pkg::IdxBits-1:0];
        state_d = S_LATCH;
      end
      S_LATCH: begin
        cand_d  = rd_data_q;
        j_d     = '0;
        rank_d  = '0;
        pend_d  = 1'b0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (j_q != size_q) begin
          rd_addr = j_q[mbrc_pkg::IdxBits-1:0];
          j_d     = j_q + mbrc_pkg::cnt_t'(1);
          pend_d  = 1'b1;
        end else begin
          pend_d  = 1'b0;
        end
        if (pend_q && (cand_q >= rd_data_q)) begin
          rank_d = rank_q + mbrc_pkg::cnt_t'(1);
        end
        if ((j_q == size_q) && !pend_q) begin
          if (rank_q == target_q) begin
            hit_d   = 1'b1;
            res_d   = cand_q;
            state_d = S_DONE;
          end else if (i_nxt == size_q) begin
            hit_d   = 1'b0;
            res_d   = '0;
            state_d = S_DONE;
          end else begin
            i_d     = i_nxt;
            state_d = S_CAND;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          median_d    = mbrc_pkg::median_t'(res_q);
          found_d     = hit_q;
          ovfl_d      = ovf_q;
          count_d     = '0;
          ovf_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      size_q      <= '0;
      target_q    <= '0;
      i_q         <= '0;
      j_q         <= '0;
      rank_q      <= '0;
      pend_q      <= 1'b0;
      cand_q      <= '0;
      res_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      median_q    <= '0;
      found_q     <= 1'b0;
      ovfl_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      size_q      <= size_d;
      target_q    <= target_d;
      i_q         <= i_d;
      j_q         <= j_d;
      rank_q      <= rank_d;
      pend_q      <= pend_d;
      cand_q      <= cand_d;
      res_q       <= res_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      median_q    <= median_d;
      found_q     <= found_d;
      ovfl_q      <= ovfl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[count_q[mbrc_pkg::IdxBits-1:0]] <= item_i.sample;
    end
    rd_data_q <= store_q[rd_addr];
  end

endmodule

[rtl/median_by_rank_count_core.sv]
// ----------------------------------------------------------------------------
// median_by_rank_count_core
// Rank-count median selector: loads a set of signed samples and returns the
// first loaded sample whose rank equals size/2+1.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one sample per beat;
//   final_item_i marks the last beat of a set. Output channel
//   (out_valid_o/out_ready_i) carries one result beat per set: median_o,
//   found_o and overflowed_o.
//   Samples beyond 64 per set are dropped and flagged in overflowed_o.
//   A four-entry queue decouples the input from the search engine, so
//   non-final beats are taken one per cycle while the engine is idle.
//   The search runs on one comparator and one store read port: each
//   stored value in turn is read as a candidate, then the whole store is
//   scanned to count the values at or below it; the search stops at a match.
//   The input stalls while the engine searches and the queue is full.
//   A stalled receiver holds the result register; the engine keeps
//   loading the next set and waits only if a second result is ready.
//   Reset clears the queue, counts and result register; the store
//   itself needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module median_by_rank_count_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [31:0]     sample_i,
  input  logic                   final_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [31:0]     median_o,
  output logic                   found_o,
  output logic                   overflowed_o
);

  logic            item_valid;
  logic            item_ready;
  mbrc_pkg::item_t item;

  mbrc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .final_item_i (final_item_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  mbrc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .median_o     (median_o),
    .found_o      (found_o),
    .overflowed_o (overflowed_o)
  );

endmodule

[rtl/mbrc_checker.sv]
// ----------------------------------------------------------------------------
// mbrc_checker
// Port-level checks of the rank-count median core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "median_by_rank_count_core_macros.svh"

module mbrc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic        final_item_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [31:0] median_o,
  input  logic        found_o,
  input  logic        overflowed_o
);

  logic [3:0] pending_q;
  logic       fin_acc;
  logic       out_acc;

  assign fin_acc = in_valid_i && in_ready_o && final_item_i;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 4'(fin_acc) - 4'(out_acc);
    end
  end

  `MBRC_ASSERT_IMPL(a_no_phantom_result, out_acc, pending_q != 4'd0)
  `MBRC_ASSERT_IMPL(a_zero_when_missing, out_valid_o && !found_o, median_o == 32'd0)
  `MBRC_ASSERT_HOLD(a_result_held, out_valid_o, out_ready_i, {median_o, found_o, overflowed_o})

endmodule

bind median_by_rank_count_core mbrc_checker u_mbrc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .final_item_i (final_item_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .median_o     (median_o),
  .found_o      (found_o),
  .overflowed_o (overflowed_o)
);

[verif/median_by_rank_count_core_tb.sv]
// ----------------------------------------------------------------------------
// median_by_rank_count_core_tb
// Loads signed sample sets into the rank-count median core and checks each
// result beat against a local rank-selection model of the set. A short table
// covers extremes, odd and even sets, sets with no rank match and a
// store overflow. Random sets of mixed sizes and value spreads follow, with
// random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module median_by_rank_count_core_tb;

  localparam int TotalItems  = 700;
  localparam int TailCycles  = mbrc_pkg::Capacity * (mbrc_pkg::Capacity + 3) + 100;
  localparam int ReportLimit = 10;

  typedef struct packed {
    mbrc_pkg::median_t median;
    logic              found;
    logic              overflowed;
  } median_result_t;

  typedef struct packed {
    mbrc_pkg::value_t sample;
    logic             fin;
    int               reps;
    logic             typed;
    median_result_t   want;
  } stim_row_t;

  localparam mbrc_pkg::value_t MinVal = 32'sh8000_0000;
  localparam mbrc_pkg::value_t MaxVal = 32'sh7fff_ffff;
  localparam median_result_t NoWant = '{32'sd0, 1'b0, 1'b0};

  localparam int DirRows = 17;
  localparam stim_row_t DirTable [DirRows] = '{
    '{MinVal,    1'b1, 1,  1'b1, '{MinVal, 1'b1, 1'b0}},
    '{MaxVal,    1'b1, 1,  1'b1, '{MaxVal, 1'b1, 1'b0}},
    '{32'sd0,    1'b1, 1,  1'b1, '{32'sd0, 1'b1, 1'b0}},
    '{32'sd5,    1'b0, 1,  1'b0, NoWant},
    '{-32'sd3,   1'b0, 1,  1'b0, NoWant},
    '{32'sd9,    1'b1, 1,  1'b0, NoWant},
    '{32'sd1,    1'b0, 1,  1'b0, NoWant},
    '{32'sd2,    1'b0, 1,  1'b0, NoWant},
    '{32'sd3,    1'b0, 1,  1'b0, NoWant},
    '{32'sd4,    1'b1, 1,  1'b0, NoWant},
    '{32'sd7,    1'b0, 2,  1'b0, NoWant},
    '{32'sd7,    1'b1, 1,  1'b1, '{32'sd0, 1'b0, 1'b0}},
    '{MaxVal,    1'b0, 1,  1'b0, NoWant},
    '{MinVal,    1'b0, 1,  1'b0, NoWant},
    '{-32'sd1,   1'b1, 1,  1'b0, NoWant},
    '{32'sd3,    1'b0, 64, 1'b0, NoWant},
    '{32'sd9,    1'b1, 1,  1'b1, '{32'sd0, 1'b0, 1'b1}}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  mbrc_pkg::sample_t sample_i = '0;
  logic              final_item_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  mbrc_pkg::median_t median_o;
  logic              found_o;
  logic              overflowed_o;

  logic           beat_typed = 1'b0;
  median_result_t beat_want = NoWant;
  bit             no_idle = 1'b0;

  mbrc_pkg::value_t held_values [mbrc_pkg::Capacity];
  int               held_count = 0;
  bit               drop_seen = 1'b0;
  median_result_t   pending_medians [$];
  int               mismatches = 0;
  int               items_sent = 0;

  median_by_rank_count_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .final_item_i (final_item_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .median_o     (median_o),
    .found_o      (found_o),
    .overflowed_o (overflowed_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_set_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 90) return $urandom_range(9, 24);
    if (r < 97) return $urandom_range(25, mbrc_pkg::Capacity);
    return $urandom_range(mbrc_pkg::Capacity + 1, mbrc_pkg::Capacity + 8);
  endfunction

  function automatic mbrc_pkg::value_t draw_value(int mode);
    case (mode)
      0: return mbrc_pkg::value_t'($urandom);
      1: return mbrc_pkg::value_t'($urandom_range(0, 4)) - 32'sd2;
      2: begin
        case ($urandom_range(0, 4))
          0: return MinVal;
          1: return MaxVal;
          2: return -32'sd1;
          3: return 32'sd1;
          default: return 32'sd0;
        endcase
      end
      default: return ($urandom_range(0, 1) == 0) ? mbrc_pkg::value_t'($urandom)
                                                  : draw_value(2);
    endcase
  endfunction

  function automatic median_result_t rank_select_median();
    median_result_t r;
    int unsigned    target;
    int unsigned    rank;
    r = '{32'sd0, 1'b0, drop_seen};
    target = held_count / 2 + 1;
    for (int i = 0; i < held_count; i++) begin
      rank = 0;
      for (int j = 0; j < held_count; j++) begin
        if (held_values[i] >= held_values[j]) rank++;
      end
      if (rank == target) begin
        r.median = held_values[i];
        r.found  = 1'b1;
        return r;
      end
    end
    return r;
  endfunction

  task automatic take_beat();
    median_result_t r;
    if (held_count < mbrc_pkg::Capacity) begin
      held_values[held_count] = sample_i;
      held_count++;
    end else begin
      drop_seen = 1'b1;
    end
    if (final_item_i) begin
      r = rank_select_median();
      if (beat_typed) r = beat_want;
      pending_medians.push_back(r);
      held_count = 0;
      drop_seen  = 1'b0;
    end
  endtask

  task automatic check_result();
    median_result_t w;
    if (pending_medians.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportLimit)
        $display("unexpected result beat: median %0d found %0b overflowed %0b",
                 median_o, found_o, overflowed_o);
    end else begin
      w = pending_medians.pop_front();
      if (median_o !== w.median || found_o !== w.found || overflowed_o !== w.overflowed) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("result mismatch: median %0d/%0d found %0b/%0b overflowed %0b/%0b",
                   w.median, median_o, w.found, found_o, w.overflowed, overflowed_o);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) take_beat();
      if (out_valid_o && out_ready_i) check_result();
    end
  end

  task automatic drive_beat(input mbrc_pkg::value_t s, input logic fin, input logic typed,
                            input median_result_t want);
    int gap;
    gap = (no_idle || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    sample_i     <= s;
    final_item_i <= fin;
    beat_typed   <= typed;
    beat_want    <= want;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_medians.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat (pick_gap()) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  initial begin
    int size;
    int mode;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DirRows; r++) begin
      for (int k = 0; k < DirTable[r].reps; k++)
        drive_beat(DirTable[r].sample, DirTable[r].fin, DirTable[r].typed, DirTable[r].want);
    end
    wait_drained();

    while (items_sent < TotalItems) begin
      no_idle = ($urandom_range(0, 5) == 0);
      size = pick_set_size();
      mode = $urandom_range(0, 3);
      for (int k = 0; k < size; k++)
        drive_beat(draw_value(mode), k == size - 1, 1'b0, NoWant);
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_medians.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
